/* hw/rtl/assert_macros.svh */
// Assertion macros used by the tunnel handshake checker RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define CHK_IMP(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("handshake checker assertion failed");
`define CHK_NXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("handshake checker assertion failed");
`else
`define CHK_IMP(lbl, ck, rn, ante, cons)
`define CHK_NXT(lbl, ck, rn, ante, cons)
`endif
`endif

/* hw/rtl/thc_pkg.sv */
// Types, constants and transition function of the tunnel handshake checker.
`default_nettype none

package thc_pkg;

	typedef enum logic [4:0] {
		ST_CSEND_HELLO     = 5'd0,
		ST_CWAIT_HELLO_ACK = 5'd1,
		ST_CSEND_AUTH      = 5'd2,
		ST_CWAIT_AUTH_RES  = 5'd3,
		ST_SWAIT_HELLO     = 5'd4,
		ST_SSEND_HELLO_ACK = 5'd5,
		ST_SWAIT_AUTH      = 5'd6,
		ST_SSEND_AUTH_RES  = 5'd7,
		ST_AUTHED          = 5'd8,
		ST_CSEND_WHELLO    = 5'd9,
		ST_CWAIT_WACC      = 5'd10,
		ST_SWAIT_WHELLO    = 5'd11,
		ST_SSEND_WACC      = 5'd12,
		ST_WIDLE           = 5'd13,
		ST_CCONN_LOCAL     = 5'd14,
		ST_SWAIT_LOCAL     = 5'd15,
		ST_RELAY           = 5'd16,
		ST_CLOSING         = 5'd17
	} state_t;

	typedef enum logic [4:0] {
		MSG_HELLO       = 5'd0,
		MSG_HELLO_ACK   = 5'd1,
		MSG_AUTH        = 5'd2,
		MSG_AUTH_OK     = 5'd3,
		MSG_AUTH_ERR    = 5'd4,
		MSG_REG         = 5'd5,
		MSG_REG_OK      = 5'd6,
		MSG_REG_ERR     = 5'd7,
		MSG_UNREG       = 5'd8,
		MSG_UNREG_OK    = 5'd9,
		MSG_REQ_WORKERS = 5'd10,
		MSG_WHELLO      = 5'd11,
		MSG_WACC        = 5'd12,
		MSG_START_RELAY = 5'd13,
		MSG_LOCAL_OK    = 5'd14,
		MSG_LOCAL_ERR   = 5'd15,
		MSG_PING        = 5'd16,
		MSG_PONG        = 5'd17,
		MSG_GOAWAY      = 5'd18,
		MSG_ERROR       = 5'd19
	} msg_t;

	typedef enum logic {
		OP_RECV = 1'b0,
		OP_SEND = 1'b1
	} op_t;

	typedef enum logic {
		REG_PEER_ROLE       = 1'b0,
		REG_CONNECTION_KIND = 1'b1
	} reg_idx_t;

	localparam logic [31:0] CONTROL_SET = 32'h000F_07FF;
	localparam logic [31:0] WORKER_SET  = 32'h000C_F800;
	localparam logic [31:0] REQUEST_SET = 32'h0003_0120;
	localparam logic [31:0] REPLY_SET   = 32'h0003_06C0;

	typedef struct packed {
		logic   ok;
		state_t nxt;
	} dec_t;

	function automatic state_t start_state(logic server, logic worker);
		state_t s;
		if (!worker) begin
			s = server ? ST_SWAIT_HELLO : ST_CSEND_HELLO;
		end else begin
			s = server ? ST_SWAIT_WHELLO : ST_CSEND_WHELLO;
		end
		return s;
	endfunction

	function automatic dec_t decide(state_t s, logic send, logic [4:0] m, logic server,
			logic worker);
		dec_t        d;
		logic        recv;
		logic [31:0] kind_set;
		logic [31:0] allow;
		d.ok     = 1'b0;
		d.nxt    = s;
		recv     = ~send;
		kind_set = worker ? WORKER_SET : CONTROL_SET;
		allow    = ((!server) == send) ? REQUEST_SET : REPLY_SET;
		priority if (s == ST_RELAY || s == ST_CLOSING || s > ST_CLOSING || m > MSG_ERROR) begin
			d.ok = 1'b0;
		end else if (m == MSG_GOAWAY || m == MSG_ERROR) begin
			d.ok  = 1'b1;
			d.nxt = ST_CLOSING;
		end else if (!kind_set[m]) begin
			d.ok = 1'b0;
		end else begin
			unique case (s)
				ST_CSEND_HELLO: begin
					if (send && m == MSG_HELLO) begin
						d.ok = 1'b1; d.nxt = ST_CWAIT_HELLO_ACK;
					end
				end
				ST_CWAIT_HELLO_ACK: begin
					if (recv && m == MSG_HELLO_ACK) begin
						d.ok = 1'b1; d.nxt = ST_CSEND_AUTH;
					end
				end
				ST_CSEND_AUTH: begin
					if (send && m == MSG_AUTH) begin
						d.ok = 1'b1; d.nxt = ST_CWAIT_AUTH_RES;
					end
				end
				ST_CWAIT_AUTH_RES: begin
					if (recv && m == MSG_AUTH_OK) begin
						d.ok = 1'b1; d.nxt = ST_AUTHED;
					end else if (recv && m == MSG_AUTH_ERR) begin
						d.ok = 1'b1; d.nxt = ST_CLOSING;
					end
				end
				ST_SWAIT_HELLO: begin
					if (recv && m == MSG_HELLO) begin
						d.ok = 1'b1; d.nxt = ST_SSEND_HELLO_ACK;
					end
				end
				ST_SSEND_HELLO_ACK: begin
					if (send && m == MSG_HELLO_ACK) begin
						d.ok = 1'b1; d.nxt = ST_SWAIT_AUTH;
					end
				end
				ST_SWAIT_AUTH: begin
					if (recv && m == MSG_AUTH) begin
						d.ok = 1'b1; d.nxt = ST_SSEND_AUTH_RES;
					end
				end
				ST_SSEND_AUTH_RES: begin
					if (send && m == MSG_AUTH_OK) begin
						d.ok = 1'b1; d.nxt = ST_AUTHED;
					end else if (send && m == MSG_AUTH_ERR) begin
						d.ok = 1'b1; d.nxt = ST_CLOSING;
					end
				end
				ST_AUTHED: begin
					d.ok = allow[m];
				end
				ST_CSEND_WHELLO: begin
					if (send && m == MSG_WHELLO) begin
						d.ok = 1'b1; d.nxt = ST_CWAIT_WACC;
					end
				end
				ST_CWAIT_WACC: begin
					if (recv && m == MSG_WACC) begin
						d.ok = 1'b1; d.nxt = ST_WIDLE;
					end
				end
				ST_SWAIT_WHELLO: begin
					if (recv && m == MSG_WHELLO) begin
						d.ok = 1'b1; d.nxt = ST_SSEND_WACC;
					end
				end
				ST_SSEND_WACC: begin
					if (send && m == MSG_WACC) begin
						d.ok = 1'b1; d.nxt = ST_WIDLE;
					end
				end
				ST_WIDLE: begin
					if (!server && recv && m == MSG_START_RELAY) begin
						d.ok = 1'b1; d.nxt = ST_CCONN_LOCAL;
					end else if (server && send && m == MSG_START_RELAY) begin
						d.ok = 1'b1; d.nxt = ST_SWAIT_LOCAL;
					end
				end
				ST_CCONN_LOCAL: begin
					if (send && m == MSG_LOCAL_OK) begin
						d.ok = 1'b1; d.nxt = ST_RELAY;
					end else if (send && m == MSG_LOCAL_ERR) begin
						d.ok = 1'b1; d.nxt = ST_CLOSING;
					end
				end
				ST_SWAIT_LOCAL: begin
					if (recv && m == MSG_LOCAL_OK) begin
						d.ok = 1'b1; d.nxt = ST_RELAY;
					end else if (recv && m == MSG_LOCAL_ERR) begin
						d.ok = 1'b1; d.nxt = ST_CLOSING;
					end
				end
				default: begin
					d.ok = 1'b0;
				end
			endcase
		end
		return d;
	endfunction

endpackage

`default_nettype wire

/* hw/rtl/tunnel_handshake_checker.sv */
// Tunnel handshake checker: per-connection message sequence checker, top level.
// Each word on the input channel is one message seen on the connection (op 0 received,
// op 1 sent) and yields exactly one result word: accepted, the connection state after
// the message, and framed. Words are registered on entry and checked against the
// 18-state handshake machine in the next stage, which drives the output; a new word is
// taken every cycle unless out_ready stalls the output. A rejected message keeps the
// state. Writing peer_role (index 0) or connection_kind (index 1) reloads the start
// state; write them only while no word is in flight.
`default_nettype none

`include "assert_macros.svh"

module tunnel_handshake_checker (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic       op,
	input  wire logic [4:0] message_type,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic            accepted,
	output logic [4:0]      next_state,
	output logic            framed,
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic       cfg_index,
	input  wire logic       cfg_data
);

	logic              valid_s1;
	logic              op_s1;
	logic [4:0]        msg_s1;
	logic              valid_s2;
	logic              accepted_s2;
	thc_pkg::state_t   next_state_s2;
	logic              framed_s2;
	logic              peer_role_q;
	logic              connection_kind_q;
	thc_pkg::state_t   conn_state_q;
	thc_pkg::state_t   state_after;
	thc_pkg::dec_t     dec;
	logic              s2_free;
	logic              s1_move;
	logic              cfg_wr;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;
	assign s2_free   = !valid_s2 || out_ready;
	assign s1_move   = valid_s1 && s2_free;
	assign in_ready  = !valid_s1 || s2_free;

	assign dec         = thc_pkg::decide(conn_state_q, op_s1, msg_s1, peer_role_q,
		connection_kind_q);
	assign state_after = dec.ok ? dec.nxt : conn_state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_s1  <= op;
			msg_s1 <= message_type;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			accepted_s2   <= dec.ok;
			next_state_s2 <= state_after;
			framed_s2     <= !(state_after == thc_pkg::ST_RELAY ||
				state_after == thc_pkg::ST_CLOSING);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			peer_role_q       <= 1'b0;
			connection_kind_q <= 1'b0;
			conn_state_q      <= thc_pkg::ST_CSEND_HELLO;
		end else if (cfg_wr) begin
			unique case (cfg_index)
				thc_pkg::REG_PEER_ROLE: begin
					peer_role_q  <= cfg_data;
					conn_state_q <= thc_pkg::start_state(cfg_data, connection_kind_q);
				end
				thc_pkg::REG_CONNECTION_KIND: begin
					connection_kind_q <= cfg_data;
					conn_state_q      <= thc_pkg::start_state(peer_role_q, cfg_data);
				end
				default: begin
					conn_state_q <= conn_state_q;
				end
			endcase
		end else if (s1_move) begin
			conn_state_q <= state_after;
		end
	end

	assign out_valid  = valid_s2;
	assign accepted   = accepted_s2;
	assign next_state = next_state_s2;
	assign framed     = framed_s2;

	`CHK_NXT(a_cfg_reload, clk, arst_n, cfg_wr,
		conn_state_q == thc_pkg::start_state(peer_role_q, connection_kind_q))
	`CHK_NXT(a_reject_holds, clk, arst_n, s1_move && !dec.ok && !cfg_wr,
		$stable(conn_state_q))
	`CHK_NXT(a_terminal_holds, clk, arst_n,
		(conn_state_q == thc_pkg::ST_RELAY || conn_state_q == thc_pkg::ST_CLOSING) && !cfg_wr,
		$stable(conn_state_q))
	`CHK_IMP(a_framed_match, clk, arst_n, out_valid,
		framed == !(next_state == thc_pkg::ST_RELAY || next_state == thc_pkg::ST_CLOSING))
	`CHK_NXT(a_result_tracks_state, clk, arst_n, s1_move && !cfg_wr,
		next_state == conn_state_q)

endmodule

`default_nettype wire

/* verif/tunnel_handshake_checker_test.sv */
// Self-checking testbench for the tunnel handshake checker: directed and random message sessions.
`timescale 1ns / 100ps

module tunnel_handshake_checker_test;

	localparam logic [31:0] CONTROL_MSGS =
		((32'd1 << (thc_pkg::MSG_REQ_WORKERS + 1)) - 32'd1) |
		(32'd1 << thc_pkg::MSG_PING) | (32'd1 << thc_pkg::MSG_PONG) |
		(32'd1 << thc_pkg::MSG_GOAWAY) | (32'd1 << thc_pkg::MSG_ERROR);
	localparam logic [31:0] WORKER_MSGS = (32'd1 << thc_pkg::MSG_WHELLO) |
		(32'd1 << thc_pkg::MSG_WACC) | (32'd1 << thc_pkg::MSG_START_RELAY) |
		(32'd1 << thc_pkg::MSG_LOCAL_OK) | (32'd1 << thc_pkg::MSG_LOCAL_ERR) |
		(32'd1 << thc_pkg::MSG_GOAWAY) | (32'd1 << thc_pkg::MSG_ERROR);
	localparam logic [31:0] REQUEST_MSGS = (32'd1 << thc_pkg::MSG_REG) |
		(32'd1 << thc_pkg::MSG_UNREG) | (32'd1 << thc_pkg::MSG_PING) |
		(32'd1 << thc_pkg::MSG_PONG);
	localparam logic [31:0] REPLY_MSGS = (32'd1 << thc_pkg::MSG_REG_OK) |
		(32'd1 << thc_pkg::MSG_REG_ERR) | (32'd1 << thc_pkg::MSG_UNREG_OK) |
		(32'd1 << thc_pkg::MSG_REQ_WORKERS) | (32'd1 << thc_pkg::MSG_PING) |
		(32'd1 << thc_pkg::MSG_PONG);
	localparam int RANDOM_WORDS = 1250;
	localparam int QUIET_AFTER  = 1100;
	localparam int LONG_HOLD    = 200;

	typedef struct packed {
		logic            ok;
		thc_pkg::state_t nxt;
	} verdict_t;

	typedef struct {
		logic       ok;
		logic [4:0] st;
		logic       framed;
	} outcome_t;

	typedef struct {
		logic       sent;
		logic [4:0] code;
	} message_t;

	logic       clk;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic       op = 1'b0;
	logic [4:0] message_type = '0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic       accepted;
	logic [4:0] next_state;
	logic       framed;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic       cfg_index = thc_pkg::REG_PEER_ROLE;
	logic       cfg_data = 1'b0;

	message_t pending_msgs[$];
	outcome_t expected_outcomes[$];

	thc_pkg::state_t conn_model;
	logic            role_model = 1'b0;
	logic            kind_model = 1'b0;
	thc_pkg::state_t gen_state;
	logic            gen_role = 1'b0;
	logic            gen_kind = 1'b0;

	int       issued_cnt = 0;
	int       in_done_cnt = 0;
	int       gap_left = 0;
	int       stall_left = 0;
	int       hold_left = 0;
	int       hold_requests = 0;
	int       holds_served = 0;
	logic     quiet = 1'b0;
	int       errors = 0;
	int       words_checked = 0;
	int       words_accepted = 0;
	int       random_words = 0;
	int       sessions = 0;
	bit [17:0] states_seen = '0;

	message_t next_msg;
	verdict_t step_verdict;
	outcome_t step_outcome;
	outcome_t want;

	tunnel_handshake_checker dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.op           (op),
		.message_type (message_type),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.accepted     (accepted),
		.next_state   (next_state),
		.framed       (framed),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	function automatic thc_pkg::state_t home_state(logic server, logic worker);
		if (worker)
			return server ? thc_pkg::ST_SWAIT_WHELLO : thc_pkg::ST_CSEND_WHELLO;
		return server ? thc_pkg::ST_SWAIT_HELLO : thc_pkg::ST_CSEND_HELLO;
	endfunction

	function automatic verdict_t judge(thc_pkg::state_t cur, logic sent, logic [4:0] code,
			logic server, logic worker);
		verdict_t        v;
		thc_pkg::state_t go;
		logic            got;
		logic [31:0]     kinds;
		logic [31:0]     dir_set;
		v.ok    = 1'b0;
		v.nxt   = cur;
		go      = cur;
		got     = ~sent;
		kinds   = worker ? WORKER_MSGS : CONTROL_MSGS;
		dir_set = (server != sent) ? REQUEST_MSGS : REPLY_MSGS;
		if (cur == thc_pkg::ST_RELAY || cur == thc_pkg::ST_CLOSING ||
				cur > thc_pkg::ST_CLOSING || code > thc_pkg::MSG_ERROR)
			return v;
		if (code == thc_pkg::MSG_GOAWAY || code == thc_pkg::MSG_ERROR) begin
			v.ok  = 1'b1;
			v.nxt = thc_pkg::ST_CLOSING;
			return v;
		end
		if (!kinds[code])
			return v;
		case (cur)
			thc_pkg::ST_CSEND_HELLO:
				if (sent && code == thc_pkg::MSG_HELLO) go = thc_pkg::ST_CWAIT_HELLO_ACK;
			thc_pkg::ST_CWAIT_HELLO_ACK:
				if (got && code == thc_pkg::MSG_HELLO_ACK) go = thc_pkg::ST_CSEND_AUTH;
			thc_pkg::ST_CSEND_AUTH:
				if (sent && code == thc_pkg::MSG_AUTH) go = thc_pkg::ST_CWAIT_AUTH_RES;
			thc_pkg::ST_CWAIT_AUTH_RES: begin
				if (got && code == thc_pkg::MSG_AUTH_OK) go = thc_pkg::ST_AUTHED;
				else if (got && code == thc_pkg::MSG_AUTH_ERR) go = thc_pkg::ST_CLOSING;
			end
			thc_pkg::ST_SWAIT_HELLO:
				if (got && code == thc_pkg::MSG_HELLO) go = thc_pkg::ST_SSEND_HELLO_ACK;
			thc_pkg::ST_SSEND_HELLO_ACK:
				if (sent && code == thc_pkg::MSG_HELLO_ACK) go = thc_pkg::ST_SWAIT_AUTH;
			thc_pkg::ST_SWAIT_AUTH:
				if (got && code == thc_pkg::MSG_AUTH) go = thc_pkg::ST_SSEND_AUTH_RES;
			thc_pkg::ST_SSEND_AUTH_RES: begin
				if (sent && code == thc_pkg::MSG_AUTH_OK) go = thc_pkg::ST_AUTHED;
				else if (sent && code == thc_pkg::MSG_AUTH_ERR) go = thc_pkg::ST_CLOSING;
			end
			thc_pkg::ST_CSEND_WHELLO:
				if (sent && code == thc_pkg::MSG_WHELLO) go = thc_pkg::ST_CWAIT_WACC;
			thc_pkg::ST_CWAIT_WACC:
				if (got && code == thc_pkg::MSG_WACC) go = thc_pkg::ST_WIDLE;
			thc_pkg::ST_SWAIT_WHELLO:
				if (got && code == thc_pkg::MSG_WHELLO) go = thc_pkg::ST_SSEND_WACC;
			thc_pkg::ST_SSEND_WACC:
				if (sent && code == thc_pkg::MSG_WACC) go = thc_pkg::ST_WIDLE;
			thc_pkg::ST_WIDLE: begin
				if (!server && got && code == thc_pkg::MSG_START_RELAY)
					go = thc_pkg::ST_CCONN_LOCAL;
				else if (server && sent && code == thc_pkg::MSG_START_RELAY)
					go = thc_pkg::ST_SWAIT_LOCAL;
			end
			thc_pkg::ST_CCONN_LOCAL: begin
				if (sent && code == thc_pkg::MSG_LOCAL_OK) go = thc_pkg::ST_RELAY;
				else if (sent && code == thc_pkg::MSG_LOCAL_ERR) go = thc_pkg::ST_CLOSING;
			end
			thc_pkg::ST_SWAIT_LOCAL: begin
				if (got && code == thc_pkg::MSG_LOCAL_OK) go = thc_pkg::ST_RELAY;
				else if (got && code == thc_pkg::MSG_LOCAL_ERR) go = thc_pkg::ST_CLOSING;
			end
			default: ;
		endcase
		v.ok  = (cur == thc_pkg::ST_AUTHED) ? dir_set[code] : (go != cur);
		v.nxt = go;
		return v;
	endfunction

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#(5_000_000);
		$display("%0t: timeout, %0d words still expected", $time, expected_outcomes.size());
		$display("FAIL tunnel_handshake_checker");
		$finish;
	end

	// Sender: hold the word until taken, then advance.
	always @(negedge clk) begin
		if (!(in_valid && in_done_cnt != issued_cnt)) begin
			if (gap_left > 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (pending_msgs.size() != 0) begin
				next_msg = pending_msgs.pop_front();
				op <= next_msg.sent;
				message_type <= next_msg.code;
				in_valid <= 1'b1;
				issued_cnt++;
				if (!quiet && $urandom_range(0, 7) == 0)
					gap_left = $urandom_range(1, 14);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver: long hold when asked, otherwise short random stalls.
	always @(negedge clk) begin
		if (holds_served != hold_requests) begin
			holds_served = hold_requests;
			hold_left = LONG_HOLD;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
			if (!quiet && $urandom_range(0, 9) == 0)
				stall_left = $urandom_range(1, 14);
		end
	end

	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready) begin
			step_verdict = judge(conn_model, op, message_type, role_model, kind_model);
			if (step_verdict.ok)
				conn_model = step_verdict.nxt;
			step_outcome.ok = step_verdict.ok;
			step_outcome.st = conn_model;
			step_outcome.framed = !(conn_model == thc_pkg::ST_RELAY ||
				conn_model == thc_pkg::ST_CLOSING);
			expected_outcomes.push_back(step_outcome);
			in_done_cnt++;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_outcomes.size() == 0) begin
				errors++;
				$display("%0t: result word with nothing expected (accepted %0d state %0d)",
					$time, accepted, next_state);
			end else begin
				want = expected_outcomes.pop_front();
				words_checked++;
				if (want.ok)
					words_accepted++;
				if (want.st <= thc_pkg::ST_CLOSING)
					states_seen[want.st] = 1'b1;
				if (accepted !== want.ok) begin
					errors++;
					$display("%0t: accepted mismatch, expected %0d, actual %0d",
						$time, want.ok, accepted);
				end
				if (next_state !== want.st) begin
					errors++;
					$display("%0t: next_state mismatch, expected %0d, actual %0d",
						$time, want.st, next_state);
				end
				if (framed !== want.framed) begin
					errors++;
					$display("%0t: framed mismatch, expected %0d, actual %0d",
						$time, want.framed, framed);
				end
			end
		end
	end

	task automatic wait_idle();
		while (pending_msgs.size() != 0 || in_done_cnt != issued_cnt ||
				expected_outcomes.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(thc_pkg::reg_idx_t idx, logic val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			thc_pkg::REG_PEER_ROLE: role_model = val;
			thc_pkg::REG_CONNECTION_KIND: kind_model = val;
			default: ;
		endcase
		conn_model = home_state(role_model, kind_model);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic configure(logic role, logic kind);
		wait_idle();
		if ($urandom_range(0, 1)) begin
			write_reg(thc_pkg::REG_PEER_ROLE, role);
			write_reg(thc_pkg::REG_CONNECTION_KIND, kind);
		end else begin
			write_reg(thc_pkg::REG_CONNECTION_KIND, kind);
			write_reg(thc_pkg::REG_PEER_ROLE, role);
		end
		gen_role = role;
		gen_kind = kind;
		gen_state = home_state(role, kind);
		sessions++;
	endtask

	task automatic queue_msg(logic sent, logic [4:0] code);
		message_t m;
		verdict_t v;
		m.sent = sent;
		m.code = code;
		pending_msgs.push_back(m);
		v = judge(gen_state, sent, code, gen_role, gen_kind);
		if (v.ok)
			gen_state = v.nxt;
	endtask

	// Pick a message that the session accepts, other than goaway and error.
	task automatic pick_legal(output logic sent, output logic [4:0] code, output logic found);
		logic [5:0] cand[$];
		verdict_t   v;
		logic       s;
		logic [4:0] c;
		int         i;
		for (i = 0; i < 2 * thc_pkg::MSG_GOAWAY; i++) begin
			s = (i >= thc_pkg::MSG_GOAWAY);
			c = 5'(i % thc_pkg::MSG_GOAWAY);
			v = judge(gen_state, s, c, gen_role, gen_kind);
			if (v.ok)
				cand.push_back({s, c});
		end
		found = (cand.size() != 0);
		sent = 1'b0;
		code = '0;
		if (found) begin
			{sent, code} = cand[$urandom_range(0, cand.size() - 1)];
		end
	endtask

	task automatic random_session(int len);
		logic       s;
		logic [4:0] c;
		logic       found;
		int         r;
		int         k;
		for (k = 0; k < len; k++) begin
			r = $urandom_range(0, 99);
			found = 1'b0;
			if (r < 80)
				pick_legal(s, c, found);
			if (!found) begin
				s = 1'($urandom_range(0, 1));
				if (r >= 80 && r < 83)
					c = $urandom_range(0, 1) ? thc_pkg::MSG_GOAWAY : thc_pkg::MSG_ERROR;
				else
					c = 5'($urandom_range(0, 31));
			end
			queue_msg(s, c);
			random_words++;
		end
	endtask

	initial begin
		conn_model = home_state(1'b0, 1'b0);
		gen_state = conn_model;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// client control: full handshake, then direction, kind and code rejections, then close
		configure(1'b0, 1'b0);
		queue_msg(thc_pkg::OP_SEND, thc_pkg::MSG_HELLO);
		queue_msg(thc_pkg::OP_RECV, thc_pkg::MSG_HELLO_ACK);
		queue_msg(thc_pkg::OP_SEND, thc_pkg::MSG_AUTH);
		queue_msg(thc_pkg::OP_RECV, thc_pkg::MSG_AUTH_OK);
		queue_msg(thc_pkg::OP_SEND, thc_pkg::MSG_REG);
		queue_msg(thc_pkg::OP_RECV, thc_pkg::MSG_REG_OK);
		queue_msg(thc_pkg::OP_SEND, thc_pkg::MSG_REG_OK);
		queue_msg(thc_pkg::OP_SEND, thc_pkg::MSG_WHELLO);
		queue_msg(thc_pkg::OP_RECV, 5'd31);
		queue_msg(thc_pkg::OP_SEND, 5'd20);
		queue_msg(thc_pkg::OP_RECV, thc_pkg::MSG_GOAWAY);
		queue_msg(thc_pkg::OP_SEND, thc_pkg::MSG_ERROR);

		// server worker: into relay, where even goaway is refused
		configure(1'b1, 1'b1);
		queue_msg(thc_pkg::OP_RECV, thc_pkg::MSG_WHELLO);
		queue_msg(thc_pkg::OP_SEND, thc_pkg::MSG_WACC);
		queue_msg(thc_pkg::OP_SEND, thc_pkg::MSG_START_RELAY);
		queue_msg(thc_pkg::OP_RECV, thc_pkg::MSG_LOCAL_OK);
		queue_msg(thc_pkg::OP_RECV, thc_pkg::MSG_GOAWAY);
		queue_msg(thc_pkg::OP_SEND, thc_pkg::MSG_HELLO);

		// server control: failed authentication closes
		configure(1'b1, 1'b0);
		queue_msg(thc_pkg::OP_RECV, thc_pkg::MSG_HELLO);
		queue_msg(thc_pkg::OP_SEND, thc_pkg::MSG_HELLO_ACK);
		queue_msg(thc_pkg::OP_RECV, thc_pkg::MSG_AUTH);
		queue_msg(thc_pkg::OP_SEND, thc_pkg::MSG_AUTH_ERR);

		// back-pressure: receiver holds off while a long session is offered
		configure(1'b0, 1'b1);
		hold_requests++;
		random_session(60);

		while (random_words < RANDOM_WORDS) begin
			if (random_words >= QUIET_AFTER)
				quiet = 1'b1;
			configure(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
			random_session($urandom_range(3, 40));
		end

		wait_idle();
		repeat (8) @(posedge clk);
		if (expected_outcomes.size() != 0) begin
			errors++;
			$display("%0t: %0d result words never arrived", $time, expected_outcomes.size());
		end
		$display("Checked %0d result words (%0d accepted) over %0d connection sessions,",
			words_checked, words_accepted, sessions);
		$display("reaching %0d of 18 handshake states; %0d mismatches.",
			$countones(states_seen), errors);
		if (errors == 0)
			$display("PASS tunnel_handshake_checker");
		else
			$display("FAIL tunnel_handshake_checker");
		$finish;
	end

endmodule

/* tunnel_handshake_checker.f */
+incdir+hw/rtl
hw/rtl/thc_pkg.sv
hw/rtl/tunnel_handshake_checker.sv
verif/tunnel_handshake_checker_test.sv
